### rtl/best_gated_result_ring_queue_assert.svh
// Assertion macros shared by the ring queue modules.
`ifndef BEST_GATED_RESULT_RING_QUEUE_ASSERT_SVH
`define BEST_GATED_RESULT_RING_QUEUE_ASSERT_SVH

`ifndef SYNTHESIS

// Checks a property on every clock edge outside reset.
`define BGRQ_ASSERT(lbl, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
    else $error("ring queue assertion failed");

// Checks that a condition in one cycle implies another in the next.
`define BGRQ_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("ring queue assertion failed");

`else

`define BGRQ_ASSERT(lbl, prop)

`define BGRQ_ASSERT_NEXT(lbl, ante, cons)

`endif

`endif

### rtl/bgrq_pkg.sv
// Package with the types and constants of the best-gated result ring queue.
`default_nettype none

package bgrq_pkg;

  localparam int QUEUE_DEPTH = 256;
  localparam int IDX_W       = $clog2(QUEUE_DEPTH);
  localparam int CNT_W       = $clog2(QUEUE_DEPTH + 1);
  localparam int SUM_W       = CNT_W + 1;

  localparam logic signed [31:0] SCORE_MIN = 32'sh8000_0000;

  typedef enum logic [1:0] {
    CMD_PUSH  = 2'd0,
    CMD_POP   = 2'd1,
    CMD_CLEAR = 2'd2
  } cmd_t;

  typedef enum logic [2:0] {
    RES_STORED      = 3'd0,
    RES_STORED_DROP = 3'd1,
    RES_REJECTED    = 3'd2,
    RES_DROPPED     = 3'd3,
    RES_POPPED      = 3'd4,
    RES_EMPTY       = 3'd5,
    RES_CLEARED     = 3'd6
  } res_t;

  typedef enum logic {
    S_IDLE    = 1'b0,
    S_DELIVER = 1'b1
  } state_t;

  typedef struct packed {
    logic [1:0]         command;
    logic [63:0]        payload;
    logic signed [31:0] score;
    logic               heuristic;
    logic [5:0]         worker_id;
    logic [31:0]        elapsed_stamp;
  } in_word_t;

  typedef struct packed {
    logic [2:0]         status;
    logic [63:0]        out_payload;
    logic signed [31:0] out_score;
    logic               out_heuristic;
    logic [5:0]         out_worker;
    logic [31:0]        out_elapsed;
    logic [8:0]         entries_held;
    logic [31:0]        drop_total;
  } out_word_t;

  // One stored entry; the tag is the heuristic flag over the worker id.
  typedef struct packed {
    logic [63:0] payload;
    logic [31:0] score;
    logic [31:0] stamp;
    logic        heuristic;
    logic [5:0]  worker;
  } entry_t;

  localparam int ENTRY_W = $bits(entry_t);

  typedef struct packed {
    logic accept;
    logic load_out;
  } ctrl_cmd_t;

endpackage

`default_nettype wire

### rtl/best_gated_result_ring_queue.sv
// Top level of the best-gated result ring queue.
`default_nettype none

// Ring queue of up to 256 search results with push, pop and clear commands; every
// accepted word yields exactly one result word. The accept cycle updates the head,
// fill count, drop counter and best score and issues the entry memory access, and
// in S_DELIVER the result then moves, with the popped entry from the memory's
// registered read port, into the output register once that register is free.
// A result waiting in the output register does not block acceptance of the next
// word; that word's result is held until the output register frees up. The
// entry memory needs no clearing after reset.
module best_gated_result_ring_queue import bgrq_pkg::*; (
  input  wire logic     clk,
  input  wire logic     rst_n,
  input  wire logic     in_valid,
  output logic          in_stall,
  input  wire in_word_t in_word,
  output logic          out_valid,
  input  wire logic     out_stall,
  output out_word_t     out_word
);

  ctrl_cmd_t ctrl_cmd;

  bgrq_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .cmd_o     (ctrl_cmd)
  );

  bgrq_dp u_dp (
    .clk      (clk),
    .rst_n    (rst_n),
    .cmd      (ctrl_cmd),
    .in_word  (in_word),
    .out_word (out_word)
  );

endmodule

`default_nettype wire

### rtl/bgrq_ram.sv
// Generic single-write, single-read RAM with a registered read port.
`default_nettype none

module bgrq_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  wire logic                     clk,
  input  wire logic                     wr_en,
  input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
  input  wire logic [WIDTH-1:0]         wr_data,
  input  wire logic                     rd_en,
  input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic      [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem_r [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem_r[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem_r[rd_addr];
    end
  end

endmodule

`default_nettype wire

### rtl/bgrq_ctrl.sv
// Controller state machine: input acceptance and output register handshake.
`default_nettype none
`include "best_gated_result_ring_queue_assert.svh"

module bgrq_ctrl import bgrq_pkg::*; (
  input  wire logic  clk,
  input  wire logic  rst_n,
  input  wire logic  in_valid,
  output logic       in_stall,
  output logic       out_valid,
  input  wire logic  out_stall,
  output ctrl_cmd_t  cmd_o
);

  state_t state_r, state_nxt;
  logic   out_valid_r, out_valid_nxt;
  logic   out_free;

  // The output register can take a word when it is empty or being drained now.
  assign out_free = !out_valid_r || !out_stall;

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          state_nxt = S_DELIVER;
        end
      end
      S_DELIVER: begin
        if (out_free) begin
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_comb begin
    in_stall       = 1'b1;
    cmd_o.accept   = 1'b0;
    cmd_o.load_out = 1'b0;
    case (state_r)
      S_IDLE: begin
        in_stall     = 1'b0;
        cmd_o.accept = in_valid;
      end
      S_DELIVER: begin
        cmd_o.load_out = out_free;
      end
      default: ;
    endcase
  end

  always_comb begin
    out_valid_nxt = out_valid_r && out_stall;
    if (cmd_o.load_out) begin
      out_valid_nxt = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign out_valid = out_valid_r;

  `BGRQ_ASSERT_NEXT(a_accept_to_deliver, cmd_o.accept, state_r == S_DELIVER)
  `BGRQ_ASSERT(a_no_overwrite, (out_valid_r && out_stall) |-> !cmd_o.load_out)
  `BGRQ_ASSERT(a_rose_from_deliver, $rose(out_valid_r) |-> $past(state_r == S_DELIVER))

endmodule

`default_nettype wire

### rtl/bgrq_dp.sv
// Datapath: ring pointers, drop counter, best score, entry memory and result registers.
`default_nettype none
`include "best_gated_result_ring_queue_assert.svh"

module bgrq_dp import bgrq_pkg::*; (
  input  wire logic      clk,
  input  wire logic      rst_n,
  input  wire ctrl_cmd_t cmd,
  input  wire in_word_t  in_word,
  output out_word_t      out_word
);

  logic [IDX_W-1:0]   head_r, head_nxt;
  logic [CNT_W-1:0]   fill_r, fill_nxt;
  logic [31:0]        drop_r, drop_nxt;
  logic signed [31:0] best_r, best_nxt;

  res_t               res_h_r, res_nxt;
  logic [8:0]         entries_h_r;
  logic [31:0]        drop_h_r;
  out_word_t          out_word_r;

  logic               full;
  logic [SUM_W-1:0]   tail_sum;
  logic [IDX_W-1:0]   tail_idx;
  logic [IDX_W-1:0]   head_inc;
  logic [31:0]        drop_inc;

  logic               wr_en;
  logic [IDX_W-1:0]   wr_addr;
  entry_t             wr_entry;
  logic               rd_en;
  logic [ENTRY_W-1:0] rd_data;
  entry_t             rd_entry;

  assign full     = fill_r == CNT_W'(QUEUE_DEPTH);
  assign tail_sum = SUM_W'(head_r) + SUM_W'(fill_r);
  assign tail_idx = (tail_sum >= SUM_W'(QUEUE_DEPTH)) ?
                    IDX_W'(tail_sum - SUM_W'(QUEUE_DEPTH)) : IDX_W'(tail_sum);
  assign head_inc = (head_r == IDX_W'(QUEUE_DEPTH - 1)) ? '0 : head_r + 1'b1;
  assign drop_inc = (drop_r == '1) ? drop_r : drop_r + 32'd1;

  assign wr_entry.payload   = in_word.payload;
  assign wr_entry.score     = in_word.score;
  assign wr_entry.stamp     = in_word.elapsed_stamp;
  assign wr_entry.heuristic = in_word.heuristic;
  assign wr_entry.worker    = in_word.worker_id;

  always_comb begin
    head_nxt = head_r;
    fill_nxt = fill_r;
    drop_nxt = drop_r;
    best_nxt = best_r;
    res_nxt  = RES_EMPTY;
    wr_en    = 1'b0;
    wr_addr  = tail_idx;
    rd_en    = 1'b0;
    if (cmd.accept) begin
      case (cmd_t'(in_word.command))
        CMD_PUSH: begin
          if (in_word.heuristic && (in_word.score <= best_r)) begin
            res_nxt = RES_REJECTED;
          end else begin
            if (in_word.heuristic) begin
              best_nxt = in_word.score;
            end
            if (full && in_word.heuristic) begin
              // Overwrite the oldest slot and move the head past it.
              wr_en    = 1'b1;
              wr_addr  = head_r;
              head_nxt = head_inc;
              drop_nxt = drop_inc;
              res_nxt  = RES_STORED_DROP;
            end else if (full) begin
              drop_nxt = drop_inc;
              res_nxt  = RES_DROPPED;
            end else begin
              wr_en    = 1'b1;
              fill_nxt = fill_r + 1'b1;
              res_nxt  = RES_STORED;
            end
          end
        end
        CMD_POP: begin
          if (fill_r != '0) begin
            rd_en    = 1'b1;
            head_nxt = head_inc;
            fill_nxt = fill_r - 1'b1;
            res_nxt  = RES_POPPED;
          end
        end
        CMD_CLEAR: begin
          head_nxt = '0;
          fill_nxt = '0;
          drop_nxt = '0;
          best_nxt = SCORE_MIN;
          res_nxt  = RES_CLEARED;
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      head_r <= '0;
      fill_r <= '0;
      drop_r <= '0;
      best_r <= SCORE_MIN;
    end else begin
      head_r <= head_nxt;
      fill_r <= fill_nxt;
      drop_r <= drop_nxt;
      best_r <= best_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      res_h_r     <= res_nxt;
      entries_h_r <= 9'(fill_nxt);
      drop_h_r    <= drop_nxt;
    end
  end

  bgrq_ram #(
    .WIDTH (ENTRY_W),
    .DEPTH (QUEUE_DEPTH)
  ) u_ram (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_entry),
    .rd_en   (rd_en),
    .rd_addr (head_r),
    .rd_data (rd_data)
  );

  assign rd_entry = rd_data;

  // Entry fields are shown only for a popped word and read as zero otherwise.
  always_ff @(posedge clk) begin
    if (cmd.load_out) begin
      out_word_r.status       <= res_h_r;
      out_word_r.entries_held <= entries_h_r;
      out_word_r.drop_total   <= drop_h_r;
      if (res_h_r == RES_POPPED) begin
        out_word_r.out_payload   <= rd_entry.payload;
        out_word_r.out_score     <= rd_entry.score;
        out_word_r.out_heuristic <= rd_entry.heuristic;
        out_word_r.out_worker    <= rd_entry.worker;
        out_word_r.out_elapsed   <= rd_entry.stamp;
      end else begin
        out_word_r.out_payload   <= '0;
        out_word_r.out_score     <= '0;
        out_word_r.out_heuristic <= 1'b0;
        out_word_r.out_worker    <= '0;
        out_word_r.out_elapsed   <= '0;
      end
    end
  end

  assign out_word = out_word_r;

  `BGRQ_ASSERT(a_fill_max, fill_r <= CNT_W'(QUEUE_DEPTH))
  `BGRQ_ASSERT_NEXT(a_drop_sat, (drop_r == '1) && (drop_nxt != '0), drop_r == '1)

endmodule

`default_nettype wire
